[rtl/core/mp2a_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2a_pkg
// Shared types and constants of the 2x2 max pooling block.
// ----------------------------------------------------------------------------
package mp2a_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int DIM_REG_BITS   = 11;
    localparam int CHAN_REG_BITS  = 7;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_cfg_reg;

    // Position of one sample inside its pooling window
    typedef struct packed {
        logic first;      // top-left sample, starts a fresh window
        logic row_off;
        logic col_off;
        logic win_done;   // bottom-right sample, window complete
        logic frame_end;  // last window and channel of the map
    } t_pos_flags;

endpackage

[rtl/core/mp2a_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2a_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read of the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module mp2a_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32768
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mp2a_addr_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2a_addr_gen
// Configuration registers and the column / row / channel scan counters.
// Produces the line store address and the window position of each sample.
// ----------------------------------------------------------------------------
module mp2a_addr_gen #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_CHANNELS = 64,
    parameter int AW           = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [mp2a_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_advance,
    output logic [AW-1:0]                       o_addr,
    output mp2a_pkg::t_pos_flags                o_flags
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int ROWW = $clog2(MAX_HEIGHT);
    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WL   = $clog2(MAX_WIDTH + 1);
    localparam int HL   = $clog2(MAX_HEIGHT + 1);
    localparam int CL   = $clog2(MAX_CHANNELS + 1);
    localparam int RST_W = (32 > MAX_WIDTH) ? MAX_WIDTH : 32;
    localparam int RST_H = (32 > MAX_HEIGHT) ? MAX_HEIGHT : 32;

    logic [WL-1:0]   r_w_lim;
    logic [HL-1:0]   r_h_lim;
    logic [CL-1:0]   r_c_lim;
    logic [COLW-1:0] r_col, n_col;
    logic [ROWW-1:0] r_row, n_row;
    logic [CHW-1:0]  r_chan, n_chan;

    logic chan_last, col_last, row_last;

    // Limits are stored already clamped: zero acts as one, too large saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_lim <= WL'(RST_W);
            r_h_lim <= HL'(RST_H);
            r_c_lim <= CL'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mp2a_pkg::REG_IMAGE_WIDTH: begin
                    if (32'(i_cfg_data) > MAX_WIDTH) begin
                        r_w_lim <= WL'(MAX_WIDTH);
                    end else if (i_cfg_data == '0) begin
                        r_w_lim <= WL'(1);
                    end else begin
                        r_w_lim <= WL'(i_cfg_data);
                    end
                end
                mp2a_pkg::REG_IMAGE_HEIGHT: begin
                    if (32'(i_cfg_data) > MAX_HEIGHT) begin
                        r_h_lim <= HL'(MAX_HEIGHT);
                    end else if (i_cfg_data == '0) begin
                        r_h_lim <= HL'(1);
                    end else begin
                        r_h_lim <= HL'(i_cfg_data);
                    end
                end
                mp2a_pkg::REG_CHANNEL_COUNT: begin
                    if (32'(i_cfg_data[mp2a_pkg::CHAN_REG_BITS-1:0]) > MAX_CHANNELS) begin
                        r_c_lim <= CL'(MAX_CHANNELS);
                    end else if (i_cfg_data[mp2a_pkg::CHAN_REG_BITS-1:0] == '0) begin
                        r_c_lim <= CL'(1);
                    end else begin
                        r_c_lim <= CL'(i_cfg_data[mp2a_pkg::CHAN_REG_BITS-1:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign chan_last = (CL'(r_chan) + CL'(1)) >= r_c_lim;
    assign col_last  = (WL'(r_col) + WL'(1)) >= r_w_lim;
    assign row_last  = (HL'(r_row) + HL'(1)) >= r_h_lim;

    always_comb begin
        n_chan = r_chan;
        n_col  = r_col;
        n_row  = r_row;
        if (!chan_last) begin
            n_chan = r_chan + CHW'(1);
        end else begin
            n_chan = '0;
            if (!col_last) begin
                n_col = r_col + COLW'(1);
            end else begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + ROWW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_advance) begin
            r_chan <= n_chan;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    // Entry of (output column, channel)
    assign o_addr = AW'(32'(r_col >> 1) * MAX_CHANNELS + 32'(r_chan));

    always_comb begin
        o_flags.first     = !r_col[0] && !r_row[0];
        o_flags.row_off   = r_row[0];
        o_flags.col_off   = r_col[0];
        o_flags.win_done  = (r_col[0] || col_last) && (r_row[0] || row_last);
        o_flags.frame_end = chan_last && col_last && row_last;
    end

endmodule

[rtl/core/mp2a_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2a_out_fifo
// Two-entry output queue that decouples the pooling pipeline from the
// downstream receiver.
// ----------------------------------------------------------------------------
module mp2a_out_fifo #(
    parameter int WIDTH = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic [1:0]       o_count
);

    logic [WIDTH-1:0] r_buf [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

[rtl/core/max_pool_2x2_with_argmax.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_with_argmax
// 2x2 stride-2 max pooling over an interleaved multi-channel stream, with
// the row and column offset of each window's winning sample.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel in raster order, channel fastest.
//   Each 2x2 window (partial at an odd right or bottom edge) yields one
//   m_axis transaction per channel: max value, winner row and column offset,
//   and tlast on the final result of the map. The earliest sample wins ties.
//   The cfg channel writes image width, height and channel count (indexes
//   0, 1, 2); write them only while no sample is in flight.
// Throughput and data path:
//   One sample per clock while the output queue has room. Running maxima
//   live in a line store indexed by (output column, channel); each sample
//   does one read in its accept cycle and one compare and write-back in the
//   next, with a forward path for back-to-back hits on one entry. A result
//   goes from the compare stage into the output queue, which drives m_axis.
// Reset and stall:
//   Reset clears the scan position and the output queue and restores the
//   default geometry (32 x 32, one channel). A stalled receiver fills the
//   two-entry output queue; s_axis tready then drops until space frees up.
// ----------------------------------------------------------------------------
module max_pool_2x2_with_argmax #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_CHANNELS = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mp2a_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // sample stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: sample, zero padded to bytes
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: max_value, win_row, win_col, zero padded to bytes
    output logic [((SAMPLE_BITS + 9) / 8) * 8 - 1:0] o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    localparam int OUT_COLS    = (MAX_WIDTH + 1) / 2;
    localparam int STORE_DEPTH = OUT_COLS * MAX_CHANNELS;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int EW          = SAMPLE_BITS + 2;     // value, row_off, col_off
    localparam int OW          = ((SAMPLE_BITS + 9) / 8) * 8;

    logic                 s_accept;
    logic [AW-1:0]        rd_addr;
    mp2a_pkg::t_pos_flags pos_flags;
    logic [EW-1:0]        rd_entry;

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [AW-1:0]                 r_s1_addr;
    mp2a_pkg::t_pos_flags          r_s1_flags;

    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [EW-1:0] r_fwd_entry;

    logic [EW-1:0]                 old_entry;
    logic signed [SAMPLE_BITS-1:0] old_value;
    logic [EW-1:0]                 cur_entry;
    logic                          wr_en;
    logic                          push;
    logic                          pop;
    logic [EW:0]                   fifo_in;
    logic [EW:0]                   fifo_out;
    logic [1:0]                    fifo_count;
    logic [2:0]                    occupancy;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_axis_tvalid && o_s_axis_tready;

    mp2a_addr_gen #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_addr_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (s_accept),
        .o_addr      (rd_addr),
        .o_flags     (pos_flags)
    );

    mp2a_ram #(
        .WIDTH (EW),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (cur_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    // Stage 1: the store read for this sample is under way
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
            r_s1_addr   <= rd_addr;
            r_s1_flags  <= pos_flags;
        end
    end

    // Write issued in the same cycle as this sample's read: RAM returned stale data
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            old_entry = r_fwd_entry;
        end else begin
            old_entry = rd_entry;
        end
        old_value = old_entry[SAMPLE_BITS-1:0];
        if (r_s1_flags.first) begin
            cur_entry = {1'b0, 1'b0, r_s1_sample};
        end else if (r_s1_sample > old_value) begin
            cur_entry = {r_s1_flags.col_off, r_s1_flags.row_off, r_s1_sample};
        end else begin
            cur_entry = old_entry;
        end
    end

    assign wr_en = r_s1_valid && !r_s1_flags.win_done;
    assign push  = r_s1_valid && r_s1_flags.win_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr  <= r_s1_addr;
        r_fwd_entry <= cur_entry;
    end

    assign fifo_in = {r_s1_flags.frame_end, cur_entry};
    assign pop     = o_m_axis_tvalid && i_m_axis_tready;

    mp2a_out_fifo #(
        .WIDTH (EW + 1)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fifo_in),
        .i_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .o_data  (fifo_out),
        .o_count (fifo_count)
    );

    // Take a sample only if the queue will still have room for its result
    assign occupancy       = 3'(fifo_count) + 3'(push);
    assign o_s_axis_tready = occupancy <= (3'(1) + 3'(pop));

    assign o_m_axis_tdata = OW'(fifo_out[EW-1:0]);
    assign o_m_axis_tlast = fifo_out[EW];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && fifo_count == 2'd2))
        else $error("output queue overflow");

    a_stage_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_s1_valid)
        else $error("accepted sample did not reach the compare stage");

    a_write_or_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && push))
        else $error("sample both written back and emitted");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

[tb/max_pool_2x2_with_argmax_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_with_argmax_test
// Self-checking bench for the 2x2 stride-2 max pooling block with winner
// offsets. A queue-fed driver streams feature maps in bursts while the
// result side stalls on its own pattern. Every accepted sample runs through
// a behavioral pooling model, and each result transaction is checked field
// by field against the oldest predicted window maximum. Geometry changes
// only while the block is drained. Some of those changes land mid-map, on
// an even row boundary or partway through a single-row or single-column map.
// ----------------------------------------------------------------------------
module max_pool_2x2_with_argmax_test;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int MAX_CH        = 64;
    localparam int STORE_SLOTS   = (MAX_W / 2) * MAX_CH;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 350;
    localparam logic [mp2a_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    // 3x3 map, two channels: partial right and bottom windows, ties, and
    // a single-sample corner window
    localparam logic [15:0] CORNER_MAP [18] = '{
        16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000,
        16'h0005, 16'h0000, 16'h0005, 16'h7FFF, 16'h0000, 16'hFFFF,
        16'h0003, 16'hFFFB, 16'h0007, 16'hFFFB, 16'h7FFF, 16'h8000
    };

    typedef enum {RECV_OPEN, RECV_PATTERN, RECV_LONG} t_recv_mode;
    typedef enum {VAL_FULL, VAL_TIES, VAL_EXTREME} t_value_mode;

    typedef struct {
        logic signed [15:0] value;
        bit                 row_off;
        bit                 col_off;
    } t_window_max;

    typedef struct {
        logic signed [15:0] value;
        bit                 row_off;
        bit                 col_off;
        bit                 last;
    } t_pool_result;

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_cfg_valid     = 1'b0;
    logic                                o_cfg_ready;
    logic [mp2a_pkg::CFG_INDEX_BITS-1:0] i_cfg_index     = '0;
    logic [mp2a_pkg::CFG_DATA_BITS-1:0]  i_cfg_data      = '0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [15:0]                         i_s_axis_tdata  = '0;    // sample
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [23:0]                         o_m_axis_tdata; // max_value, win_row, win_col
    logic                                o_m_axis_tlast;

    // behavioral pooling state
    logic [mp2a_pkg::DIM_REG_BITS-1:0]  cfg_width  = 11'd32;
    logic [mp2a_pkg::DIM_REG_BITS-1:0]  cfg_height = 11'd32;
    logic [mp2a_pkg::CHAN_REG_BITS-1:0] cfg_chans  = 7'd1;
    logic [9:0]                         pos_col    = '0;
    logic [9:0]                         pos_row    = '0;
    logic [5:0]                         pos_chan   = '0;
    t_window_max                        running_max [STORE_SLOTS];

    logic [15:0]  sample_queue [$];
    t_pool_result pending_maxima [$];

    int         mismatch_count = 0;
    int         idle_cycles    = 0;
    bit         sample_taken   = 1'b0;
    bit         send_bursty    = 1'b0;
    int         burst_left     = 1;
    int         gap_left       = 0;
    t_recv_mode recv_mode      = RECV_OPEN;
    logic [15:0] stall_pattern = 16'hFFFF;
    int         stall_left     = 0;

    max_pool_2x2_with_argmax dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int dim_limit(input int raw, input int ceiling);
        if (raw == 0) return 1;
        if (raw > ceiling) return ceiling;
        return raw;
    endfunction

    // Advance the pooling model by one sample and queue any window result
    function automatic void pool_sample(input logic [15:0] raw);
        int           w;
        int           h;
        int           c;
        int           slot;
        bit           chan_last;
        bit           col_last;
        bit           row_last;
        bit           col_odd;
        bit           row_odd;
        logic signed [15:0] s;
        t_window_max  cur;
        t_pool_result res;
        w = dim_limit(int'(cfg_width), MAX_W);
        h = dim_limit(int'(cfg_height), MAX_H);
        c = dim_limit(int'(cfg_chans), MAX_CH);
        s = raw;
        chan_last = int'(pos_chan) + 1 >= c;
        col_last  = int'(pos_col) + 1 >= w;
        row_last  = int'(pos_row) + 1 >= h;
        col_odd   = pos_col[0];
        row_odd   = pos_row[0];
        slot = int'(pos_col >> 1) * MAX_CH + int'(pos_chan);
        if (!col_odd && !row_odd) begin
            cur.value   = s;
            cur.row_off = 1'b0;
            cur.col_off = 1'b0;
        end else begin
            cur = running_max[slot];
            // strict compare: the earliest sample keeps a tie
            if (s > cur.value) begin
                cur.value   = s;
                cur.row_off = row_odd;
                cur.col_off = col_odd;
            end
        end
        if ((col_odd || col_last) && (row_odd || row_last)) begin
            res.value   = cur.value;
            res.row_off = cur.row_off;
            res.col_off = cur.col_off;
            res.last    = chan_last && col_last && row_last;
            pending_maxima.push_back(res);
        end else begin
            running_max[slot] = cur;
        end
        if (!chan_last) begin
            pos_chan = pos_chan + 1'b1;
        end else begin
            pos_chan = '0;
            if (!col_last) begin
                pos_col = pos_col + 1'b1;
            end else begin
                pos_col = '0;
                pos_row = row_last ? '0 : pos_row + 1'b1;
            end
        end
    endfunction

    function automatic logic [15:0] pick_sample(input t_value_mode vmode);
        case (vmode)
            VAL_TIES: return 16'(int'($urandom_range(0, 3)) - 2);
            VAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected,
                     actual);
            mismatch_count++;
        end
    endtask

    // Wait until every sample is in and every result is out, then settle
    task automatic drain();
        while (sample_queue.size() != 0 || i_s_axis_tvalid || pending_maxima.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mp2a_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [mp2a_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_geometry(input int w, input int h, input int c);
        write_reg(mp2a_pkg::REG_IMAGE_WIDTH, 11'(w));
        write_reg(mp2a_pkg::REG_IMAGE_HEIGHT, 11'(h));
        write_reg(mp2a_pkg::REG_CHANNEL_COUNT, 11'(c));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Queue random samples under fresh pacing on both sides, then drain
    task automatic feed(input int count);
        t_value_mode vmode;
        vmode         = t_value_mode'($urandom_range(0, 2));
        send_bursty   = $urandom_range(0, 2) != 0;
        recv_mode     = t_recv_mode'($urandom_range(0, 2));
        stall_pattern = 16'($urandom) | 16'h0001;
        repeat (count) sample_queue.push_back(pick_sample(vmode));
        drain();
    endtask

    // Sample driver: hold until the transaction completes, pace in bursts
    always @(negedge i_clk) begin : sample_driver
        logic next_valid;
        next_valid = i_s_axis_tvalid;
        if (i_s_axis_tvalid && sample_taken)
            next_valid = 1'b0;
        sample_taken = 1'b0;
        if (!next_valid && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (sample_queue.size() != 0) begin
                i_s_axis_tdata <= sample_queue.pop_front();
                next_valid = 1'b1;
                if (send_bursty) begin
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(1, 10);
                    end
                end
            end
        end
        i_s_axis_tvalid <= next_valid;
    end

    always @(negedge i_clk) begin : result_receiver
        case (recv_mode)
            RECV_PATTERN: begin
                i_m_axis_tready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
            RECV_LONG: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_axis_tready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(2, 12);
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end
            default: i_m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin : stream_monitor
        t_pool_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (mp2a_pkg::t_cfg_reg'(i_cfg_index))
                    mp2a_pkg::REG_IMAGE_WIDTH:   cfg_width  = i_cfg_data;
                    mp2a_pkg::REG_IMAGE_HEIGHT:  cfg_height = i_cfg_data;
                    mp2a_pkg::REG_CHANNEL_COUNT:
                        cfg_chans = i_cfg_data[mp2a_pkg::CHAN_REG_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sample_taken = 1'b1;
                pool_sample(i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_maxima.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value %0d last %0b",
                             $time, $signed(o_m_axis_tdata[15:0]), o_m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = pending_maxima.pop_front();
                    check_field("max_value", int'(want.value),
                                int'($signed(o_m_axis_tdata[15:0])));
                    check_field("win_row", int'(want.row_off), int'(o_m_axis_tdata[16]));
                    check_field("win_col", int'(want.col_off), int'(o_m_axis_tdata[17]));
                    check_field("frame_end", int'(want.last), int'(o_m_axis_tlast));
                    check_field("tdata padding", 0, int'(o_m_axis_tdata[23:18]));
                end
            end
        end
    end

    // Stop a hung run: count cycles without any transaction
    always @(posedge i_clk) begin : watchdog
        if ((i_cfg_valid && o_cfg_ready) || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int w;
        int h;
        int c;
        int w2;
        int h2;
        int c2;
        int random_items;
        random_items = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // odd edges, ties and the full sample range
        set_geometry(3, 3, 2);
        foreach (CORNER_MAP[i]) sample_queue.push_back(CORNER_MAP[i]);
        drain();

        // zero registers act as one: every sample is its own window
        write_reg(REG_UNUSED, 11'h7FF);
        set_geometry(0, 0, 0);
        feed(4);

        // shrink the height below the current row: that row becomes the last
        set_geometry(2, 6, 1);
        feed(4);
        set_geometry(2, 1, 1);
        feed(2);

        // oversized registers saturate; shrink them mid-map to close the map
        set_geometry(11'h7FF, 1, 1);
        feed(8);
        set_geometry(9, 1, 1);
        feed(1);
        set_geometry(1, 11'h7FF, 1);
        feed(8);
        set_geometry(1, 9, 1);
        feed(1);
        // channel write keeps its low bits only
        set_geometry(2, 2, 11'h0C2);
        feed(4 * MAX_CH);

        while (random_items < RANDOM_ITEMS) begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 7);
            c = $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(1, 3);
                h = $urandom_range(1, 3);
                c = $urandom_range(5, MAX_CH);
            end
            set_geometry((w == 1 && $urandom_range(0, 2) == 0) ? 0 : w,
                         (h == 1 && $urandom_range(0, 2) == 0) ? 0 : h,
                         (c == 1 && $urandom_range(0, 2) == 0) ? 0 : c);
            if (h >= 3 && $urandom_range(0, 3) == 0) begin
                // change geometry at the start of row two, mid-map
                feed(2 * w * c);
                w2 = $urandom_range(1, 9);
                h2 = $urandom_range(1, 6);
                c2 = $urandom_range(1, 4);
                set_geometry(w2, h2, c2);
                feed((h2 <= 2) ? w2 * c2 : (h2 - 2) * w2 * c2);
                random_items += 2 * w * c + ((h2 <= 2) ? w2 * c2 : (h2 - 2) * w2 * c2);
            end else begin
                feed(w * h * c);
                random_items += w * h * c;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/mp2a_pkg.sv
rtl/core/mp2a_ram.sv
rtl/core/mp2a_addr_gen.sv
rtl/core/mp2a_out_fifo.sv
rtl/core/max_pool_2x2_with_argmax.sv
tb/max_pool_2x2_with_argmax_test.sv
